/* design/spq_pkg.sv */
package spq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int KEY_W        = 32;
  localparam int FILL_W       = 5;
  localparam int STATUS_W     = 2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic signed [KEY_W-1:0] value;
  } cell_ctrl_t;

endpackage

/* design/spq_if.sv */
interface spq_req_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic signed [spq_pkg::KEY_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface spq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::STATUS_W-1:0]        status;
  logic signed [spq_pkg::KEY_W-1:0]    data;
  logic [spq_pkg::FILL_W-1:0]          fill_count;
  logic                                is_empty;
  logic                                is_full;

  modport source (output valid, status, data, fill_count, is_empty, is_full, input ready);
  modport sink   (input valid, status, data, fill_count, is_empty, is_full, output ready);
endinterface

/* design/spq_cell.sv */
module spq_cell (
  input  logic                             clk,
  input  spq_pkg::cell_ctrl_t              ctrl,
  input  logic                             occupied,
  input  logic                             left_ins,
  input  logic signed [spq_pkg::KEY_W-1:0] left_key,
  input  logic signed [spq_pkg::KEY_W-1:0] right_key,
  output logic                             ins,
  output logic signed [spq_pkg::KEY_W-1:0] key
);

  // ins: the new key belongs at or before this cell
  assign ins = !occupied || (key > ctrl.value);

  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (ins) begin
        key <= left_ins ? left_key : ctrl.value;
      end
    end else if (ctrl.deq) begin
      key <= right_key;
    end
  end

endmodule

/* design/sorted_priority_queue.sv */
// Sorted minimum priority queue built as a row of shifting cells.
// req channel: cmd (enqueue or dequeue) and a signed 32-bit value; a
// transaction completes when valid and ready are both high at a clock edge.
// rsp channel: one transaction per request carrying status, the removed
// key (data, zero unless a dequeue succeeded), fill_count, is_empty, is_full.
// Every cell compares the broadcast key with its own in parallel, so an
// enqueue or dequeue finishes in a single cycle: the response appears one
// cycle after the request is taken and a new request may be taken every
// cycle. The response register is the only stage between the channels.
// A full enqueue returns status full, an empty dequeue returns status empty,
// and neither changes the held keys.
// Equal keys leave in arrival order.
// rst (synchronous) empties the queue and drops a pending response; cell
// contents are not cleared, they are ignored beyond the fill count.
// While rsp is stalled, req.ready stays low and the response holds.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
  input logic        clk,
  input logic        rst,
  spq_req_if.sink    req,
  spq_rsp_if.source  rsp
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic [OCC_W-1:0]                 occ;
  logic [OCC_W-1:0]                 occ_next;
  logic                             full;
  logic                             empty;
  logic                             accept;
  logic                             enq_ok;
  logic                             deq_ok;
  spq_pkg::cell_ctrl_t              ctrl;
  logic [CAPACITY-1:0]              cell_ins;
  logic signed [spq_pkg::KEY_W-1:0] cell_key [CAPACITY];
  logic [OCC_W+spq_pkg::FILL_W-1:0] occ_ext;
  logic [spq_pkg::STATUS_W-1:0]     status_next;

  assign full   = (occ == OCC_W'(CAPACITY));
  assign empty  = (occ == '0);
  assign accept = req.valid && req.ready;
  assign enq_ok = accept && (req.cmd == spq_pkg::CMD_ENQ) && !full;
  assign deq_ok = accept && (req.cmd == spq_pkg::CMD_DEQ) && !empty;

  assign ctrl.enq   = enq_ok;
  assign ctrl.deq   = deq_ok;
  assign ctrl.value = req.value;

  assign req.ready = !rsp.valid || rsp.ready;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                             l_ins;
      logic signed [spq_pkg::KEY_W-1:0] l_key;
      logic signed [spq_pkg::KEY_W-1:0] r_key;
      if (i == 0) begin : g_first
        assign l_ins = 1'b0;
        assign l_key = req.value;
      end else begin : g_mid
        assign l_ins = cell_ins[i-1];
        assign l_key = cell_key[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign r_key = cell_key[i];
      end else begin : g_inner
        assign r_key = cell_key[i+1];
      end
      spq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occupied  (occ > OCC_W'(i)),
        .left_ins  (l_ins),
        .left_key  (l_key),
        .right_key (r_key),
        .ins       (cell_ins[i]),
        .key       (cell_key[i])
      );
    end
  endgenerate

  always_comb begin
    occ_next = occ;
    if (enq_ok) begin
      occ_next = occ + OCC_W'(1);
    end else if (deq_ok) begin
      occ_next = occ - OCC_W'(1);
    end
  end

  always_comb begin
    status_next = spq_pkg::ST_DONE;
    if (req.cmd == spq_pkg::CMD_ENQ && full) begin
      status_next = spq_pkg::ST_FULL;
    end else if (req.cmd == spq_pkg::CMD_DEQ && empty) begin
      status_next = spq_pkg::ST_EMPTY;
    end
  end

  assign occ_ext = {{spq_pkg::FILL_W{1'b0}}, occ_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      occ <= occ_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status     <= status_next;
      rsp.data       <= deq_ok ? cell_key[0] : '0;
      rsp.fill_count <= occ_ext[spq_pkg::FILL_W-1:0];
      rsp.is_empty   <= (occ_next == '0);
      rsp.is_full    <= (occ_next == OCC_W'(CAPACITY));
    end
  end

endmodule

/* design/spq_checker.sv */
module spq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [spq_pkg::STATUS_W-1:0]     rsp_status,
  input logic signed [spq_pkg::KEY_W-1:0] rsp_data,
  input logic [spq_pkg::FILL_W-1:0]       rsp_fill_count,
  input logic                             rsp_is_empty,
  input logic                             rsp_is_full
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_req_to_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted request produced no response");

  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_empty |-> rsp_fill_count == '0 && !rsp_is_full)
    else $error("empty flag disagrees with fill count");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == spq_pkg::ST_FULL |-> rsp_is_full && rsp_data == '0)
    else $error("full refusal without full queue");

  a_empty_refuse: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == spq_pkg::ST_EMPTY |-> rsp_is_empty && rsp_data == '0)
    else $error("empty refusal without empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_data       (rsp.data),
  .rsp_fill_count (rsp.fill_count),
  .rsp_is_empty   (rsp.is_empty),
  .rsp_is_full    (rsp.is_full)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int CAPACITY   = spq_pkg::DEF_CAPACITY;
  localparam int RAND_ITEMS = 1330;
  localparam int LONG_HOLD  = 120;
  localparam int DRAIN_WAIT = 20;
  localparam longint CYCLE_LIMIT = 800000;

  localparam logic signed [spq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [spq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [spq_pkg::STATUS_W-1:0]     status;
    logic signed [spq_pkg::KEY_W-1:0] data;
    logic [spq_pkg::FILL_W-1:0]       fill_count;
    logic                             is_empty;
    logic                             is_full;
  } pq_result_t;

  class pq_scoreboard;
    logic signed [spq_pkg::KEY_W-1:0] held_keys[$];
    pq_result_t                       pending_results[$];
    int                               errors;

    function void note_op(logic cmd, logic signed [spq_pkg::KEY_W-1:0] key);
      pq_result_t r;
      int pos;
      r.status = spq_pkg::ST_DONE;
      r.data   = '0;
      if (cmd == spq_pkg::CMD_ENQ) begin
        if (held_keys.size() >= CAPACITY) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          pos = held_keys.size();
          while (pos > 0 && held_keys[pos-1] > key) pos--;
          held_keys.insert(pos, key);
        end
      end else begin
        if (held_keys.size() == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.data = held_keys.pop_front();
        end
      end
      r.fill_count = spq_pkg::FILL_W'(held_keys.size());
      r.is_empty   = (held_keys.size() == 0);
      r.is_full    = (held_keys.size() == CAPACITY);
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(pq_result_t got);
      pq_result_t exp;
      if (pending_results.size() == 0) begin
        report("response transaction with no request outstanding");
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status || got.data !== exp.data ||
            got.fill_count !== exp.fill_count || got.is_empty !== exp.is_empty ||
            got.is_full !== exp.is_full)
          report($sformatf({"got status=%0d data=%0d fill=%0d empty=%b full=%b, ",
                            "exp status=%0d data=%0d fill=%0d empty=%b full=%b"},
                           got.status, got.data, got.fill_count, got.is_empty,
                           got.is_full, exp.status, exp.data, exp.fill_count,
                           exp.is_empty, exp.is_full));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  spq_req_if req_ch();
  spq_rsp_if rsp_ch();

  sorted_priority_queue #(.CAPACITY(CAPACITY)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pq_scoreboard sb = new();
  longint       cycle_count = 0;
  int           rsp_count   = 0;
  bit           no_idle     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    pq_result_t got;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** sorted_priority_queue: FAILED **");
      $finish;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status     = rsp_ch.status;
      got.data       = rsp_ch.data;
      got.fill_count = rsp_ch.fill_count;
      got.is_empty   = rsp_ch.is_empty;
      got.is_full    = rsp_ch.is_full;
      sb.check_result(got);
      rsp_count++;
    end
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_op(req_ch.cmd, req_ch.value);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [spq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      5, 6:    return $signed($urandom_range(0, 8)) - 4;
      7: begin
        case ($urandom_range(0, 3))
          0:       return KEY_MIN;
          1:       return KEY_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
      8:       return KEY_MIN + $urandom_range(0, 3);
      9:       return KEY_MAX - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // response side: random stalls, plus two long holds that back up the request side
  initial begin
    int gap;
    int hold_idx;
    int hold_at[2];
    hold_at  = '{400, 1000};
    hold_idx = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_idx < 2 && rsp_count >= hold_at[hold_idx]) begin
        hold_idx++;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  task send_op(logic cmd, logic signed [spq_pkg::KEY_W-1:0] key);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= cmd;
    req_ch.value <= key;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task idle_req(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task wait_drained();
    idle_req(1);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [spq_pkg::KEY_W-1:0] seed_keys[16];
    int sent;
    int seg_len;
    int enq_pct;
    bit paused;

    req_ch.valid = 1'b0;
    req_ch.cmd   = spq_pkg::CMD_ENQ;
    req_ch.value = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty dequeue, extremes, ties, fill to full, full enqueue, dequeues
    seed_keys = '{KEY_MAX, KEY_MIN, 0, -1, 1, 32'sh5555_5555, 32'shAAAA_AAAA, 7,
                  7, 7, -7, KEY_MIN, KEY_MAX, 0, 32'sh0000_FFFF, 32'shFFFF_0000};
    send_op(spq_pkg::CMD_DEQ, KEY_MAX);
    idle_req(pick_gap());
    foreach (seed_keys[i]) begin
      send_op(spq_pkg::CMD_ENQ, seed_keys[i]);
      idle_req(pick_gap());
    end
    send_op(spq_pkg::CMD_ENQ, 3);
    repeat (4) send_op(spq_pkg::CMD_DEQ, KEY_MIN);
    wait_drained();

    sent   = 0;
    paused = 0;
    while (sent < RAND_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 3))
        0:       enq_pct = 20;
        1:       enq_pct = 80;
        2:       enq_pct = 95;
        default: enq_pct = 50;
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      repeat (seg_len) begin
        if (sent < RAND_ITEMS) begin
          send_op(($urandom_range(1, 100) <= enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ,
                  pick_key());
          sent++;
          idle_req(pick_gap());
        end
      end
      if (!paused && sent >= RAND_ITEMS / 2) begin
        paused = 1;
        wait_drained();
      end
    end
    no_idle = 0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
